[rtl/pcsc_pkg.sv]
// Shared constants and types of the pixel color space converter.
package pcsc_pkg;

  // Divider geometry: quotient bits, dividend and divisor widths
  localparam int QuoW   = 15;
  localparam int DvdW   = 24;
  localparam int DvsW   = 9;
  localparam int DivLat = QuoW + 1;

  // Pixel modes
  localparam logic MODE_RGB = 1'b0;
  localparam logic MODE_YCC = 1'b1;

  // Result fields that ride alongside the divider
  typedef struct packed {
    logic [15:0] luma;
    logic [15:0] cb;
    logic [15:0] cr;
    logic [7:0]  value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        hue_zero;
    logic        sat_zero;
  } side_t;

endpackage

[rtl/pcsc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
module pcsc_div_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pcsc_pkg::DvdW-1:0]     dividend_i,
  input  logic [pcsc_pkg::DvsW-1:0]     divisor_i,
  output logic [pcsc_pkg::QuoW-1:0]     quotient_o
);

  logic [pcsc_pkg::DvdW-1:0] rem_r [0:pcsc_pkg::QuoW];
  logic [pcsc_pkg::DvsW-1:0] dvs_r [0:pcsc_pkg::QuoW];
  logic [pcsc_pkg::QuoW-1:0] quo_r [0:pcsc_pkg::QuoW];
  logic [pcsc_pkg::DvdW-1:0] rem_nxt [1:pcsc_pkg::QuoW];
  logic [pcsc_pkg::QuoW-1:0] quo_nxt [1:pcsc_pkg::QuoW];

  // Trial subtract of the shifted divisor, one bit per stage, MSB first
  always_comb begin
    logic [pcsc_pkg::DvdW:0] trial;
    logic [pcsc_pkg::DvdW-1:0] shd;
    for (int k = 1; k <= pcsc_pkg::QuoW; k++) begin
      shd = pcsc_pkg::DvdW'(dvs_r[k-1]) << (pcsc_pkg::QuoW - k);
      trial = {1'b0, rem_r[k-1]} - {1'b0, shd};
      rem_nxt[k] = rem_r[k-1];
      quo_nxt[k] = quo_r[k-1];
      if (!trial[pcsc_pkg::DvdW]) begin
        rem_nxt[k] = trial[pcsc_pkg::DvdW-1:0];
        quo_nxt[k][pcsc_pkg::QuoW-k] = 1'b1;
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dividend_i;
      dvs_r[0] <= divisor_i;
      quo_r[0] <= '0;
      for (int k = 1; k <= pcsc_pkg::QuoW; k++) begin
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_r[k-1];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quotient_o = quo_r[pcsc_pkg::QuoW];

endmodule

[rtl/pixel_color_space_converter.sv]
// Top level of the pixel color space converter.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_red, in_green, in_blue, in_luma,
//          |                      | in_chroma_blue, in_chroma_red
//  out     | out_valid / out_ready| out_luma .. out_value, out_red .. out_blue
//  cfg     | cfg_we               | cfg_wdata (pixel mode)
//
// One item per cycle while the output is not stalled; the path runs through two
// arithmetic stages, the 16-stage hue and saturation dividers, and the output register.
// Reset clears all valid bits and sets RGB mode.
// A stall at the output freezes the whole pipeline; in_ready is low then.
module pixel_color_space_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [15:0] in_luma,
  input  logic [15:0] in_chroma_blue,
  input  logic [15:0] in_chroma_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_luma,
  output logic [15:0] out_chroma_blue,
  output logic [15:0] out_chroma_red,
  output logic [14:0] out_hue,
  output logic [12:0] out_saturation,
  output logic [7:0]  out_value,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam logic [14:0] HUE_60  = 15'd3840;
  localparam logic [14:0] HUE_120 = 15'd7680;
  localparam logic [14:0] HUE_240 = 15'd15360;
  localparam logic [14:0] HUE_360 = 15'd23040;
  localparam logic [1:0] SEC_RED_UP = 2'd0;
  localparam logic [1:0] SEC_RED_DN = 2'd1;
  localparam logic [1:0] SEC_GREEN  = 2'd2;
  localparam logic [1:0] SEC_BLUE   = 2'd3;
  localparam logic signed [17:0] K_RCR = 18'sd91881;
  localparam logic signed [17:0] K_GCB = 18'sd22554;
  localparam logic signed [17:0] K_GCR = 18'sd46802;
  localparam logic signed [17:0] K_BCB = 18'sd116130;

  // Saturate a 1/2^24 sum to a byte
  function automatic logic [7:0] to_byte(input logic signed [35:0] v);
    logic [7:0] res;
    if (v[35]) res = 8'd0;
    else if (|v[34:32]) res = 8'd255;
    else res = v[31:24];
    return res;
  endfunction

  logic mode_r;
  logic en;
  logic a_v_r, b_v_r, out_valid_r;
  logic vd_r [0:pcsc_pkg::DivLat-1];
  pcsc_pkg::side_t side_r [0:pcsc_pkg::DivLat-1];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Hold the pixel mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pcsc_pkg::MODE_RGB;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Stage A: max/min, hue sector and constant products
  logic              a_mode_r;
  logic [7:0]        a_mx_r, a_mn_r, a_r_r, a_b_r;
  logic [1:0]        a_sel_r;
  logic signed [8:0] a_sdiff_r;
  logic [23:0]       a_yr_r, a_yg_r, a_yb_r, a_cbr_r, a_cbg_r, a_crg_r, a_crb_r;
  logic [31:0]       a_ys_r;
  logic signed [34:0] a_pr_r, a_pgb_r, a_pgr_r, a_pb_r;

  logic [7:0]        mx_nxt, mn_nxt;
  logic [1:0]        sel_nxt;
  logic signed [8:0] sdiff_nxt;
  logic signed [16:0] cbs, crs;

  always_comb begin
    logic signed [8:0] rs, gs, bs;
    rs = $signed({1'b0, in_red});
    gs = $signed({1'b0, in_green});
    bs = $signed({1'b0, in_blue});
    mx_nxt = in_red;
    mn_nxt = in_red;
    if (in_green > mx_nxt) mx_nxt = in_green;
    if (in_blue > mx_nxt) mx_nxt = in_blue;
    if (in_green < mn_nxt) mn_nxt = in_green;
    if (in_blue < mn_nxt) mn_nxt = in_blue;
    // red wins ties, then green
    priority if (in_red >= in_green && in_red >= in_blue) begin
      sel_nxt   = (in_green >= in_blue) ? SEC_RED_UP : SEC_RED_DN;
      sdiff_nxt = gs - bs;
    end else if (in_green >= in_blue) begin
      sel_nxt   = SEC_GREEN;
      sdiff_nxt = bs - rs;
    end else begin
      sel_nxt   = SEC_BLUE;
      sdiff_nxt = rs - gs;
    end
  end

  assign cbs = $signed({1'b0, in_chroma_blue}) - 17'sd32768;
  assign crs = $signed({1'b0, in_chroma_red}) - 17'sd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode_r  <= mode_r;
      a_mx_r    <= mx_nxt;
      a_mn_r    <= mn_nxt;
      a_sel_r   <= sel_nxt;
      a_sdiff_r <= sdiff_nxt;
      a_r_r     <= in_red;
      a_b_r     <= in_blue;
      a_yr_r    <= 24'd19595 * 24'(in_red);
      a_yg_r    <= 24'd38470 * 24'(in_green);
      a_yb_r    <= 24'd7471 * 24'(in_blue);
      a_cbr_r   <= 24'd11058 * 24'(in_red);
      a_cbg_r   <= 24'd21710 * 24'(in_green);
      a_crg_r   <= 24'd27439 * 24'(in_green);
      a_crb_r   <= 24'd5329 * 24'(in_blue);
      a_ys_r    <= {in_luma, 16'd0};
      a_pr_r    <= crs * K_RCR;
      a_pgb_r   <= cbs * K_GCB;
      a_pgr_r   <= crs * K_GCR;
      a_pb_r    <= cbs * K_BCB;
    end
  end

  // Stage B: sums, saturation and divider operands
  pcsc_pkg::side_t          side_nxt;
  logic [pcsc_pkg::DvdW-1:0] hdvd_nxt, sdvd_nxt;
  logic [pcsc_pkg::DvsW-1:0] hdvs_nxt, sdvs_nxt;

  always_comb begin
    logic [23:0] yy, cb, cr;
    logic [7:0]  d;
    logic [22:0] base_d;
    logic signed [24:0] num_s;
    logic signed [35:0] ys;
    yy = a_yr_r + a_yg_r + a_yb_r + 24'd128;
    cb = 24'h800080 - a_cbr_r - a_cbg_r + {1'b0, a_b_r, 15'd0};
    cr = 24'h800080 + {1'b0, a_r_r, 15'd0} - a_crg_r - a_crb_r;
    d  = a_mx_r - a_mn_r;
    unique case (a_sel_r)
      SEC_RED_UP: base_d = '0;
      SEC_RED_DN: base_d = 23'(HUE_360) * 23'(d);
      SEC_GREEN:  base_d = 23'(HUE_120) * 23'(d);
      SEC_BLUE:   base_d = 23'(HUE_240) * 23'(d);
      default:    base_d = '0;
    endcase
    num_s = $signed({2'b0, base_d}) + 25'(a_sdiff_r) * $signed({10'd0, HUE_60});
    hdvd_nxt = {num_s[22:0], 1'b0} + {16'd0, d};
    hdvs_nxt = {d, 1'b0};
    sdvd_nxt = {3'd0, d, 13'd0} + {16'd0, a_mx_r};
    sdvs_nxt = {a_mx_r, 1'b0};
    ys = $signed({4'd0, a_ys_r});
    side_nxt = '0;
    if (a_mode_r == pcsc_pkg::MODE_RGB) begin
      side_nxt.luma     = yy[23:8];
      side_nxt.cb       = cb[23:8];
      side_nxt.cr       = cr[23:8];
      side_nxt.value    = a_mx_r;
      side_nxt.hue_zero = (a_mx_r == a_mn_r);
      side_nxt.sat_zero = (a_mx_r == 8'd0);
    end else begin
      side_nxt.red      = to_byte(ys + 36'(a_pr_r));
      side_nxt.green    = to_byte(ys - 36'(a_pgb_r) - 36'(a_pgr_r));
      side_nxt.blue     = to_byte(ys + 36'(a_pb_r));
      side_nxt.hue_zero = 1'b1;
      side_nxt.sat_zero = 1'b1;
    end
  end

  pcsc_pkg::side_t          b_side_r;
  logic [pcsc_pkg::DvdW-1:0] b_hdvd_r, b_sdvd_r;
  logic [pcsc_pkg::DvsW-1:0] b_hdvs_r, b_sdvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= side_nxt;
      b_hdvd_r <= hdvd_nxt;
      b_hdvs_r <= hdvs_nxt;
      b_sdvd_r <= sdvd_nxt;
      b_sdvs_r <= sdvs_nxt;
    end
  end

  // Hue and saturation dividers
  logic [pcsc_pkg::QuoW-1:0] hue_q, sat_q;

  pcsc_div_pipe u_hue_div (
    .clk        (clk),
    .en         (en),
    .dividend_i (b_hdvd_r),
    .divisor_i  (b_hdvs_r),
    .quotient_o (hue_q)
  );

  pcsc_div_pipe u_sat_div (
    .clk        (clk),
    .en         (en),
    .dividend_i (b_sdvd_r),
    .divisor_i  (b_sdvs_r),
    .quotient_o (sat_q)
  );

  // Carry valid bits and side results beside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < pcsc_pkg::DivLat; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= b_v_r;
      for (int k = 1; k < pcsc_pkg::DivLat; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= b_side_r;
      for (int k = 1; k < pcsc_pkg::DivLat; k++) side_r[k] <= side_r[k-1];
    end
  end

  // Output register: drop hue for grey and saturation for black, and both in YCbCr mode
  pcsc_pkg::side_t     last;
  logic [14:0] out_hue_r;
  logic [12:0] out_sat_r;
  logic [15:0] out_luma_r, out_cb_r, out_cr_r;
  logic [7:0]  out_value_r, out_red_r, out_green_r, out_blue_r;

  assign last = side_r[pcsc_pkg::DivLat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[pcsc_pkg::DivLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_luma_r  <= last.luma;
      out_cb_r    <= last.cb;
      out_cr_r    <= last.cr;
      out_value_r <= last.value;
      out_red_r   <= last.red;
      out_green_r <= last.green;
      out_blue_r  <= last.blue;
      out_hue_r   <= last.hue_zero ? 15'd0 : hue_q;
      out_sat_r   <= last.sat_zero ? 13'd0 : sat_q[12:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_luma        = out_luma_r;
  assign out_chroma_blue = out_cb_r;
  assign out_chroma_red  = out_cr_r;
  assign out_hue         = out_hue_r;
  assign out_saturation  = out_sat_r;
  assign out_value       = out_value_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;

endmodule

[verif/pixel_color_space_converter_tb.sv]
// Self-checking testbench of the pixel color space converter.
module pixel_color_space_converter_tb;

  localparam int Latency = 19;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] luma;
    logic [15:0] cb;
    logic [15:0] cr;
  } pixel_t;

  typedef struct packed {
    logic [15:0] luma;
    logic [15:0] cb;
    logic [15:0] cr;
    logic [14:0] hue;
    logic [12:0] sat;
    logic [7:0]  value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } conv_t;

  // Directed row: mode, pixel, flag for a typed-in result, the result
  typedef struct {
    logic   mode;
    pixel_t pix;
    bit     fixed;
    conv_t  res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic [15:0] in_luma = '0, in_chroma_blue = '0, in_chroma_red = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_luma, out_chroma_blue, out_chroma_red;
  logic [14:0] out_hue;
  logic [12:0] out_saturation;
  logic [7:0]  out_value, out_red, out_green, out_blue;

  conv_t expected_q[$];
  int    errors = 0;
  logic  cur_mode = pcsc_pkg::MODE_RGB;
  int    send_idle = 0;
  int    recv_stall = 0;

  pixel_color_space_converter u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] rdiv(logic [63:0] num, logic [63:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [7:0] sat_byte(longint v);
    if (v < 0) return 8'd0;
    v = v >>> 24;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Compute the converted pixel for the given mode
  function automatic conv_t convert(logic mode, pixel_t p);
    conv_t  c;
    longint r, g, b, yy, cbs, crs, mx, mn, d, num, ys, cbo, cro;
    c = '0;
    if (mode == pcsc_pkg::MODE_RGB) begin
      r = p.red; g = p.green; b = p.blue;
      yy  = 19595 * r + 38470 * g + 7471 * b;
      cbs = (128 << 16) - 11058 * r - 21710 * g + 32768 * b;
      crs = (128 << 16) + 32768 * r - 27439 * g - 5329 * b;
      c.luma = 16'((yy + 128) >>> 8);
      c.cb   = 16'((cbs + 128) >>> 8);
      c.cr   = 16'((crs + 128) >>> 8);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (mx != mn) begin
        d = mx - mn;
        if (mx == r) num = (g >= b) ? 3840 * (g - b) : 23040 * d - 3840 * (b - g);
        else if (mx == g) num = 7680 * d + 3840 * b - 3840 * r;
        else num = 15360 * d + 3840 * r - 3840 * g;
        c.hue = 15'(rdiv(num, d));
      end
      if (mx != 0) c.sat = 13'(rdiv(4096 * (mx - mn), mx));
      c.value = mx[7:0];
    end else begin
      ys  = longint'(p.luma) << 16;
      cbo = longint'(p.cb) - 32768;
      cro = longint'(p.cr) - 32768;
      c.red   = sat_byte(ys + 91881 * cro);
      c.green = sat_byte(ys - 22554 * cbo - 46802 * cro);
      c.blue  = sat_byte(ys + 116130 * cbo);
    end
    return c;
  endfunction

  // Idle when asked, then hold valid until the item is accepted
  task automatic send_pixel(pixel_t p, conv_t res);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_red, in_green, in_blue, in_luma, in_chroma_blue, in_chroma_red} <= p;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = 72'({$urandom, $urandom, $urandom});
    case ($urandom_range(5))
      0: p.green = p.red;
      1: p.blue = p.red;
      2: begin p.green = p.red; p.blue = p.red; end
      default: ;
    endcase
    return p;
  endfunction

  // Randomize the receiver stall each cycle
  always @(posedge clk) begin
    out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    conv_t got, exp_c;
    if (rst_n && out_valid && out_ready) begin
      got = {out_luma, out_chroma_blue, out_chroma_red, out_hue, out_saturation,
             out_value, out_red, out_green, out_blue};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_c = expected_q.pop_front();
        if (got.luma != exp_c.luma)
          $display("%0t: luma exp %h got %h", $time, exp_c.luma, got.luma);
        if (got.cb != exp_c.cb)
          $display("%0t: cb exp %h got %h", $time, exp_c.cb, got.cb);
        if (got.cr != exp_c.cr)
          $display("%0t: cr exp %h got %h", $time, exp_c.cr, got.cr);
        if (got.hue != exp_c.hue)
          $display("%0t: hue exp %0d got %0d", $time, exp_c.hue, got.hue);
        if (got.sat != exp_c.sat)
          $display("%0t: sat exp %0d got %0d", $time, exp_c.sat, got.sat);
        if (got.value != exp_c.value)
          $display("%0t: value exp %0d got %0d", $time, exp_c.value, got.value);
        if (got.red != exp_c.red)
          $display("%0t: red exp %0d got %0d", $time, exp_c.red, got.red);
        if (got.green != exp_c.green)
          $display("%0t: green exp %0d got %0d", $time, exp_c.green, got.green);
        if (got.blue != exp_c.blue)
          $display("%0t: blue exp %0d got %0d", $time, exp_c.blue, got.blue);
        if (got != exp_c) errors++;
      end
    end
  end

  initial begin
    #3000000;
    $display("pixel_color_space_converter_tb failed");
    $finish;
  end

  initial begin
    row_t   rows[$];
    row_t   rw;
    pixel_t p;
    int     phase, n;
    // Directed table: extremes, grey, black, ties, saturation in YCbCr mode
    rows.push_back('{pcsc_pkg::MODE_RGB, '0, 1, {16'h0000, 16'h8000, 16'h8000, 60'd0}});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd255, 8'd255, 8'd255, 48'd0}, 1,
                     {16'hFF00, 16'h8000, 16'h8000, 15'd0, 13'd0, 8'd255, 24'd0}});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd255, 8'd0, 8'd0, 48'd0}, 1,
                     {16'h4C3E, 16'h54F9, 16'hFF80, 15'd0, 13'd4096, 8'd255, 24'd0}});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd0, 8'd255, 8'd0, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd0, 8'd0, 8'd255, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd200, 8'd200, 8'd10, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd10, 8'd200, 8'd200, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd200, 8'd10, 8'd200, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd200, 8'd10, 8'd90, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd1, 8'd0, 8'd0, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd77, 8'd77, 8'd77, 48'd0}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_YCC, '0, 1, {84'd0, 8'd0, 8'd135, 8'd0}});
    rows.push_back('{pcsc_pkg::MODE_YCC, {24'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1,
                     {84'd0, 8'd255, 8'd120, 8'd255}});
    rows.push_back('{pcsc_pkg::MODE_YCC, {24'd0, 16'h8000, 16'h8000, 16'h8000}, 1,
                     {84'd0, 8'd128, 8'd128, 8'd128}});
    rows.push_back('{pcsc_pkg::MODE_YCC, {24'd0, 16'hFFFF, 16'h0000, 16'h0000}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_YCC, {24'd0, 16'h0000, 16'hFFFF, 16'h0000}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_YCC, {24'd0, 16'h0000, 16'h0000, 16'hFFFF}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_YCC, {24'd0, 16'h4000, 16'h8000, 16'hC000}, 0, '0});
    rows.push_back('{pcsc_pkg::MODE_RGB, {8'd255, 8'd128, 8'd0, 48'd0}, 0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Walk the directed table
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.mode != cur_mode) set_mode(rw.mode);
      send_pixel(rw.pix, rw.fixed ? rw.res : convert(rw.mode, rw.pix));
    end

    // Random phases: idling pattern changes, mode swaps between them
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      set_mode(phase[0] ? pcsc_pkg::MODE_YCC : pcsc_pkg::MODE_RGB);
      for (n = 0; n < 180; n++) begin
        p = rand_pixel();
        if (n == 90) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        send_pixel(p, convert(cur_mode, p));
      end
    end
    drain();
    if (errors == 0) begin
      $display("pixel_color_space_converter_tb passed");
    end else begin
      $display("pixel_color_space_converter_tb failed");
    end
    $finish;
  end
endmodule
